// File: sv/exl_pkg.sv
// ----------------------------------------------------------------------------
// Expression lexer package
// Shared types and constants for the streaming expression tokenizer.
// ----------------------------------------------------------------------------
package exl_pkg;

  localparam int POS_BITS   = 16;
  localparam int VALUE_BITS = 31;
  localparam int MAX_TOKENS = 3;

  localparam logic [POS_BITS-1:0]   POS_MAX = {POS_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] VAL_MAX = {VALUE_BITS{1'b1}};

  // Token kinds as they appear on the result channel.
  typedef enum logic [4:0] {
    KIND_NUM    = 5'd0,
    KIND_IDENT  = 5'd1,
    KIND_RETURN = 5'd2,
    KIND_EQ     = 5'd3,
    KIND_NE     = 5'd4,
    KIND_LE     = 5'd5,
    KIND_GE     = 5'd6,
    KIND_LT     = 5'd7,
    KIND_GT     = 5'd8,
    KIND_ASSIGN = 5'd9,
    KIND_PLUS   = 5'd10,
    KIND_MINUS  = 5'd11,
    KIND_STAR   = 5'd12,
    KIND_SLASH  = 5'd13,
    KIND_LPAREN = 5'd14,
    KIND_RPAREN = 5'd15,
    KIND_SEMI   = 5'd16,
    KIND_EOF    = 5'd17,
    KIND_ERROR  = 5'd18
  } kind_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       has_byte;
    logic       end_of_input;
  } byte_t;

  typedef struct packed {
    kind_t                 token_kind;
    logic [POS_BITS-1:0]   start_pos;
    logic [POS_BITS-1:0]   token_len;
    logic [VALUE_BITS-1:0] num_value;
    logic                  value_saturated;
    logic                  last_of_run;
  } token_t;

  // All tokens caused by one input item, in order.
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] slot;
    logic   [1:0]            count;
  } bundle_t;

endpackage

// File: sv/exl_core.sv
// ----------------------------------------------------------------------------
// Expression lexer core
// Holds the scanner state and works out, for one input item, the next state
// and the group of up to three tokens that the item produces.
// ----------------------------------------------------------------------------
module exl_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  exl_pkg::byte_t   data,
  output exl_pkg::bundle_t bundle
);

  typedef enum logic [4:0] {
    MODE_IDLE  = 5'b00001,
    MODE_IDENT = 5'b00010,
    MODE_NUM   = 5'b00100,
    MODE_HELD  = 5'b01000,
    MODE_ERROR = 5'b10000
  } mode_t;

  localparam logic [7:0] CH_BANG   = 8'h21;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_US     = 8'h5F;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_LO_R   = 8'h72;

  localparam logic [47:0] KW_TEXT = "return";
  localparam logic [2:0]  KW_FULL = 3'd6;
  localparam logic [2:0]  KW_NONE = 3'd7;

  localparam int PB  = exl_pkg::POS_BITS;
  localparam int VB  = exl_pkg::VALUE_BITS;
  localparam int MAC = exl_pkg::VALUE_BITS + 4;

  localparam logic [PB-1:0] LEN_ONE = PB'(1);
  localparam logic [PB-1:0] LEN_TWO = PB'(2);

  function automatic exl_pkg::token_t make_tok(exl_pkg::kind_t k, logic [PB-1:0] s,
                                              logic [PB-1:0] l, logic [VB-1:0] v,
                                              logic sat);
    exl_pkg::token_t t;
    t.token_kind      = k;
    t.start_pos       = s;
    t.token_len       = l;
    t.num_value       = v;
    t.value_saturated = sat;
    t.last_of_run     = 1'b0;
    return t;
  endfunction

  function automatic logic [7:0] kw_char(logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = KW_TEXT[47:40];
      3'd1:    ch = KW_TEXT[39:32];
      3'd2:    ch = KW_TEXT[31:24];
      3'd3:    ch = KW_TEXT[23:16];
      3'd4:    ch = KW_TEXT[15:8];
      3'd5:    ch = KW_TEXT[7:0];
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Token that a scanner state would give if its run ended now.
  function automatic exl_pkg::token_t pending_tok(mode_t m, logic [7:0] h,
                                                 logic [PB-1:0] s, logic [PB-1:0] l,
                                                 logic [VB-1:0] v, logic o,
                                                 logic [2:0] k);
    exl_pkg::token_t t;
    t = make_tok(exl_pkg::KIND_ERROR, s, LEN_ONE, '0, 1'b0);
    case (m)
      MODE_IDENT: begin
        t = make_tok((k == KW_FULL) ? exl_pkg::KIND_RETURN : exl_pkg::KIND_IDENT,
                     s, l, '0, 1'b0);
      end
      MODE_NUM: begin
        t = make_tok(exl_pkg::KIND_NUM, s, l, v, o);
      end
      MODE_HELD: begin
        if (h == CH_LT) begin
          t.token_kind = exl_pkg::KIND_LT;
        end else if (h == CH_GT) begin
          t.token_kind = exl_pkg::KIND_GT;
        end else if (h == CH_EQ) begin
          t.token_kind = exl_pkg::KIND_ASSIGN;
        end else begin
          t.token_kind = exl_pkg::KIND_ERROR;
        end
      end
      default: begin
        t = make_tok(exl_pkg::KIND_ERROR, s, LEN_ONE, '0, 1'b0);
      end
    endcase
    return t;
  endfunction

  mode_t         mode, mode_next, m_mode;
  logic [7:0]    held, held_next, m_held;
  logic [PB-1:0] tstart, tstart_next, m_tstart;
  logic [PB-1:0] tlen, tlen_next, m_tlen;
  logic [VB-1:0] acc, acc_next, m_acc;
  logic          ovf, ovf_next, m_ovf;
  logic [2:0]    kwp, kwp_next, m_kwp;
  logic [PB-1:0] bpos, bpos_next, m_bpos;

  logic [7:0]       c;
  logic [3:0]       digit;
  logic             is_digit, is_lower, is_word, is_space, is_held, is_op;
  logic             flush_go, start_go;
  exl_pkg::kind_t   op_kind;
  exl_pkg::kind_t   two_kind;
  logic [MAC-1:0]   mac;
  logic [1:0]       n;
  exl_pkg::bundle_t bnd;

  assign bundle = bnd;

  always_comb begin
    c        = data.text_byte;
    digit    = c[3:0] - CH_ZERO[3:0];
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    is_lower = (c >= CH_LO_A) && (c <= CH_LO_Z);
    is_word  = is_lower || is_digit || ((c >= CH_UP_A) && (c <= CH_UP_Z)) || (c == CH_US);
    is_space = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    is_held  = (c == CH_BANG) || (c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
    is_op    = 1'b1;
    case (c)
      CH_PLUS:   op_kind = exl_pkg::KIND_PLUS;
      CH_MINUS:  op_kind = exl_pkg::KIND_MINUS;
      CH_STAR:   op_kind = exl_pkg::KIND_STAR;
      CH_SLASH:  op_kind = exl_pkg::KIND_SLASH;
      CH_LPAREN: op_kind = exl_pkg::KIND_LPAREN;
      CH_RPAREN: op_kind = exl_pkg::KIND_RPAREN;
      CH_SEMI:   op_kind = exl_pkg::KIND_SEMI;
      default: begin
        op_kind = exl_pkg::KIND_ERROR;
        is_op   = 1'b0;
      end
    endcase
    if (held == CH_BANG) begin
      two_kind = exl_pkg::KIND_NE;
    end else if (held == CH_LT) begin
      two_kind = exl_pkg::KIND_LE;
    end else if (held == CH_GT) begin
      two_kind = exl_pkg::KIND_GE;
    end else begin
      two_kind = exl_pkg::KIND_EQ;
    end
    // acc * 10 + digit; it overflows exactly when the sum leaves the value range.
    mac = {4'b0, acc} + {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0} + MAC'(digit) - {4'b0, acc};

    m_mode   = mode;
    m_held   = held;
    m_tstart = tstart;
    m_tlen   = tlen;
    m_acc    = acc;
    m_ovf    = ovf;
    m_kwp    = kwp;
    m_bpos   = bpos;
    flush_go = 1'b0;
    start_go = 1'b0;
    n        = 2'd0;
    bnd      = '0;

    if (data.has_byte) begin
      m_bpos = (bpos == exl_pkg::POS_MAX) ? bpos : bpos + LEN_ONE;
      case (mode)
        MODE_ERROR: begin
          m_mode = MODE_ERROR;
        end
        MODE_HELD: begin
          if (c == CH_EQ) begin
            bnd.slot[n] = make_tok(two_kind, tstart, LEN_TWO, '0, 1'b0);
            n = n + 2'd1;
            m_mode = MODE_IDLE;
          end else begin
            flush_go = 1'b1;
            start_go = (held != CH_BANG);
          end
        end
        MODE_IDENT: begin
          if (is_word) begin
            m_tlen = (tlen == exl_pkg::POS_MAX) ? tlen : tlen + LEN_ONE;
            m_kwp  = ((kwp < KW_FULL) && (c == kw_char(kwp))) ? kwp + 3'd1 : KW_NONE;
          end else begin
            flush_go = 1'b1;
            start_go = 1'b1;
          end
        end
        MODE_NUM: begin
          if (is_digit) begin
            m_tlen = (tlen == exl_pkg::POS_MAX) ? tlen : tlen + LEN_ONE;
            if (ovf || (mac > MAC'(exl_pkg::VAL_MAX))) begin
              m_ovf = 1'b1;
              m_acc = exl_pkg::VAL_MAX;
            end else begin
              m_acc = mac[VB-1:0];
            end
          end else begin
            flush_go = 1'b1;
            start_go = 1'b1;
          end
        end
        default: begin
          start_go = 1'b1;
        end
      endcase
    end

    if (flush_go) begin
      bnd.slot[n] = pending_tok(mode, held, tstart, tlen, acc, ovf, kwp);
      n = n + 2'd1;
      m_mode = ((mode == MODE_HELD) && (held == CH_BANG)) ? MODE_ERROR : MODE_IDLE;
    end

    if (start_go) begin
      if (is_space) begin
        m_mode = MODE_IDLE;
      end else if (is_held) begin
        m_mode   = MODE_HELD;
        m_held   = c;
        m_tstart = bpos;
      end else if (is_op) begin
        bnd.slot[n] = make_tok(op_kind, bpos, LEN_ONE, '0, 1'b0);
        n = n + 2'd1;
        m_mode = MODE_IDLE;
      end else if (is_lower) begin
        m_mode   = MODE_IDENT;
        m_tstart = bpos;
        m_tlen   = LEN_ONE;
        m_kwp    = (c == CH_LO_R) ? 3'd1 : KW_NONE;
      end else if (is_digit) begin
        m_mode   = MODE_NUM;
        m_tstart = bpos;
        m_tlen   = LEN_ONE;
        m_acc    = VB'(digit);
        m_ovf    = 1'b0;
      end else begin
        bnd.slot[n] = make_tok(exl_pkg::KIND_ERROR, bpos, LEN_ONE, '0, 1'b0);
        n = n + 2'd1;
        m_mode = MODE_ERROR;
      end
    end

    if (data.end_of_input) begin
      if ((m_mode == MODE_IDENT) || (m_mode == MODE_NUM) || (m_mode == MODE_HELD)) begin
        bnd.slot[n] = pending_tok(m_mode, m_held, m_tstart, m_tlen, m_acc, m_ovf, m_kwp);
        n = n + 2'd1;
      end
      bnd.slot[n] = make_tok(exl_pkg::KIND_EOF, m_bpos, '0, '0, 1'b0);
      n = n + 2'd1;
    end

    if (n != 2'd0) begin
      bnd.slot[n - 2'd1].last_of_run = 1'b1;
    end
    bnd.count = n;

    // End of input starts a fresh text from offset zero.
    if (data.end_of_input) begin
      mode_next   = MODE_IDLE;
      held_next   = '0;
      tstart_next = '0;
      tlen_next   = '0;
      acc_next    = '0;
      ovf_next    = 1'b0;
      kwp_next    = '0;
      bpos_next   = '0;
    end else begin
      mode_next   = m_mode;
      held_next   = m_held;
      tstart_next = m_tstart;
      tlen_next   = m_tlen;
      acc_next    = m_acc;
      ovf_next    = m_ovf;
      kwp_next    = m_kwp;
      bpos_next   = m_bpos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= MODE_IDLE;
      held   <= '0;
      tstart <= '0;
      tlen   <= '0;
      acc    <= '0;
      ovf    <= 1'b0;
      kwp    <= '0;
      bpos   <= '0;
    end else if (accept) begin
      mode   <= mode_next;
      held   <= held_next;
      tstart <= tstart_next;
      tlen   <= tlen_next;
      acc    <= acc_next;
      ovf    <= ovf_next;
      kwp    <= kwp_next;
      bpos   <= bpos_next;
    end
  end

endmodule

// File: sv/expression_lexer_unit.sv
// ----------------------------------------------------------------------------
// Expression lexer
// Streaming tokenizer for a small C-like expression language.
// ----------------------------------------------------------------------------
// Usage:
//   Source text enters on the byte channel, one item per transfer. Each item
//   carries a character, a flag that the character is present and an end of
//   input flag. Tokens leave on the token channel, one per transfer; the
//   last token caused by an item has last_of_run set.
//   An item produces zero to three tokens. They appear in the output register
//   in the cycle after the item is taken, then drain one per cycle while the
//   receiver does not stall. Throughput is one item per cycle while each item
//   gives at most one token and the receiver does not stall; a larger group
//   holds the byte channel while the single token output register drains it.
//   The byte channel stalls only while tokens of an earlier item remain and
//   cannot all leave in the current cycle. When the token receiver stalls,
//   the current token holds steady and the byte channel stalls behind it.
//   Reset clears the scanner to the start of a new text at offset zero and
//   empties the token register. End of input does the same after its
//   end-of-file token.
// ----------------------------------------------------------------------------
module expression_lexer_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  output logic            byte_stall,
  input  exl_pkg::byte_t  byte_data,
  output logic            token_valid,
  input  logic            token_stall,
  output exl_pkg::token_t token_data
);

  logic                  accept;
  logic                  free;
  exl_pkg::bundle_t      bundle;
  exl_pkg::token_t [2:0] slot;
  logic [1:0]            remain;
  logic [1:0]            rd;

  // Room for a new group once the held group is empty or its last token leaves.
  assign free        = (remain == 2'd0) || ((remain == 2'd1) && !token_stall);
  assign byte_stall  = !free;
  assign accept      = byte_valid && free;
  assign token_valid = (remain != 2'd0);
  assign token_data  = slot[rd];

  exl_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .data   (byte_data),
    .bundle (bundle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      remain <= 2'd0;
      rd     <= 2'd0;
    end else if (accept) begin
      remain <= bundle.count;
      rd     <= 2'd0;
    end else if (token_valid && !token_stall) begin
      remain <= remain - 2'd1;
      rd     <= rd + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot <= bundle.slot;
    end
  end

endmodule

// File: sv/exl_checker.sv
// ----------------------------------------------------------------------------
// Expression lexer checker
// Port-level properties of the lexer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module exl_checker (
  input logic            clk,
  input logic            rst,
  input logic            byte_stall,
  input logic            token_valid,
  input logic            token_stall,
  input exl_pkg::token_t token_data
);

  // Reset empties the token register.
  assert property (@(posedge clk) rst |=> !token_valid)
    else $error("token valid after reset");

  // The byte side only waits behind tokens that are still held.
  assert property (@(posedge clk) disable iff (rst) byte_stall |-> token_valid)
    else $error("byte stall with no token held");

  // End of file always closes the run of its item.
  assert property (@(posedge clk) disable iff (rst)
    (token_valid && (token_data.token_kind == exl_pkg::KIND_EOF)) |-> token_data.last_of_run)
    else $error("eof token not last of run");

  // A stalled token stays offered and unchanged.
  assert property (@(posedge clk) disable iff (rst)
    (token_valid && token_stall) |=> (token_valid && $stable(token_data)))
    else $error("stalled token changed");

endmodule

bind expression_lexer_unit exl_checker u_exl_checker (.*);

// File: tb/tb_expression_lexer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Expression lexer testbench
// Streams source text through expression_lexer_unit, predicts the token
// stream with a scanner model kept in the bench, and compares every token
// field by field. The sender and the receiver idle at random, and the
// receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module tb_expression_lexer_unit;

  localparam int CLK_HALF     = 4;
  localparam int CYCLE_LIMIT  = 20_000;
  localparam int RANDOM_ITEMS = 135;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 80;
  localparam int HOLD_AT_ITEM = 30;
  localparam int CALM_FROM    = 100;
  localparam int CALM_TO      = 180;
  localparam int DRAIN_CYCLES = 16;
  localparam int PRINT_CAP    = 50;

  localparam int PB = exl_pkg::POS_BITS;
  localparam int VB = exl_pkg::VALUE_BITS;

  localparam logic [PB-1:0] LEN_ZERO = PB'(0);
  localparam logic [PB-1:0] LEN_ONE  = PB'(1);
  localparam logic [PB-1:0] LEN_TWO  = PB'(2);

  typedef enum logic [4:0] {
    SCAN_IDLE  = 5'b00001,
    SCAN_IDENT = 5'b00010,
    SCAN_NUM   = 5'b00100,
    SCAN_HELD  = 5'b01000,
    SCAN_ERROR = 5'b10000
  } scan_t;

  localparam logic [2:0]  KW_FULL = 3'd6;
  localparam logic [2:0]  KW_NONE = 3'd7;
  localparam logic [47:0] KEYWORD = "return";
  localparam string       WORD_CHARS =
    "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
  localparam string       OP_CHARS = "+-*/();<>=";
  localparam string       CMP_HEADS = "=!<>";

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             byte_valid = 1'b0;
  logic             byte_stall;
  exl_pkg::byte_t   byte_data = '0;
  logic             token_valid;
  logic             token_stall = 1'b0;
  exl_pkg::token_t  token_data;

  // Scanner state of the prediction.
  scan_t         scan_mode;
  logic [7:0]    held_ch;
  logic [PB-1:0] tok_start;
  logic [PB-1:0] tok_len;
  logic [VB-1:0] num_acc;
  logic          num_ovf;
  logic [2:0]    kw_prog;
  logic [PB-1:0] byte_pos;

  exl_pkg::token_t run_tokens[$];
  exl_pkg::token_t token_expect[$];
  exl_pkg::byte_t  text_queue[$];

  int          stim_items = 0;
  int          texts = 0;
  int          items_taken = 0;
  int          tokens_seen = 0;
  int          errors = 0;
  int          sat_seen = 0;
  int          cycles = 0;
  int          hold_left = 0;
  bit          hold_used = 1'b0;
  bit          byte_moved = 1'b0;
  logic [18:0] kinds_seen = '0;
  logic        calm;

  assign calm = (items_taken >= CALM_FROM) && (items_taken < CALM_TO);

  expression_lexer_unit uut (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .byte_data   (byte_data),
    .token_valid (token_valid),
    .token_stall (token_stall),
    .token_data  (token_data)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Token prediction
  // --------------------------------------------------------------------------
  task automatic clear_scanner();
    scan_mode = SCAN_IDLE;
    held_ch   = '0;
    tok_start = '0;
    tok_len   = '0;
    num_acc   = '0;
    num_ovf   = 1'b0;
    kw_prog   = '0;
    byte_pos  = '0;
  endtask

  function automatic bit is_word(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic logic [7:0] keyword_char(logic [2:0] idx);
    return KEYWORD[8*(5-idx) +: 8];
  endfunction

  task automatic add_token(exl_pkg::kind_t kind, logic [PB-1:0] start,
                           logic [PB-1:0] len, logic [VB-1:0] value,
                           logic sat);
    exl_pkg::token_t t;
    if (run_tokens.size() >= exl_pkg::MAX_TOKENS) return;
    t.token_kind      = kind;
    t.start_pos       = start;
    t.token_len       = len;
    t.num_value       = value;
    t.value_saturated = sat;
    t.last_of_run     = 1'b0;
    run_tokens.push_back(t);
  endtask

  // Emits the token in progress; leaves the scanner idle or in error.
  task automatic flush_token();
    case (scan_mode)
      SCAN_IDENT: begin
        add_token(kw_prog == KW_FULL ? exl_pkg::KIND_RETURN : exl_pkg::KIND_IDENT,
                  tok_start, tok_len, '0, 1'b0);
        scan_mode = SCAN_IDLE;
      end
      SCAN_NUM: begin
        add_token(exl_pkg::KIND_NUM, tok_start, tok_len, num_acc, num_ovf);
        scan_mode = SCAN_IDLE;
      end
      SCAN_HELD: begin
        if (held_ch == "!") begin
          add_token(exl_pkg::KIND_ERROR, tok_start, LEN_ONE, '0, 1'b0);
          scan_mode = SCAN_ERROR;
        end else begin
          add_token(held_ch == "<" ? exl_pkg::KIND_LT :
                    held_ch == ">" ? exl_pkg::KIND_GT : exl_pkg::KIND_ASSIGN,
                    tok_start, LEN_ONE, '0, 1'b0);
          scan_mode = SCAN_IDLE;
        end
      end
      default: ;
    endcase
  endtask

  task automatic begin_token(logic [7:0] c, logic [PB-1:0] pos);
    if (is_blank(c)) return;
    case (c)
      "!", "=", "<", ">": begin
        scan_mode = SCAN_HELD;
        held_ch   = c;
        tok_start = pos;
      end
      "+": add_token(exl_pkg::KIND_PLUS, pos, LEN_ONE, '0, 1'b0);
      "-": add_token(exl_pkg::KIND_MINUS, pos, LEN_ONE, '0, 1'b0);
      "*": add_token(exl_pkg::KIND_STAR, pos, LEN_ONE, '0, 1'b0);
      "/": add_token(exl_pkg::KIND_SLASH, pos, LEN_ONE, '0, 1'b0);
      "(": add_token(exl_pkg::KIND_LPAREN, pos, LEN_ONE, '0, 1'b0);
      ")": add_token(exl_pkg::KIND_RPAREN, pos, LEN_ONE, '0, 1'b0);
      ";": add_token(exl_pkg::KIND_SEMI, pos, LEN_ONE, '0, 1'b0);
      default: begin
        if (c >= "a" && c <= "z") begin
          scan_mode = SCAN_IDENT;
          tok_start = pos;
          tok_len   = LEN_ONE;
          kw_prog   = (c == "r") ? 3'd1 : KW_NONE;
        end else if (c >= "0" && c <= "9") begin
          scan_mode = SCAN_NUM;
          tok_start = pos;
          tok_len   = LEN_ONE;
          num_acc   = VB'(c - "0");
          num_ovf   = 1'b0;
        end else begin
          // Anything that starts no token is an error; the rest of the text is dropped.
          add_token(exl_pkg::KIND_ERROR, pos, LEN_ONE, '0, 1'b0);
          scan_mode = SCAN_ERROR;
        end
      end
    endcase
  endtask

  task automatic lex_item(exl_pkg::byte_t item);
    logic [7:0]      c;
    logic [PB-1:0]   pos;
    logic [31:0]     digit;
    bit              bang;
    exl_pkg::token_t tail;
    c = item.text_byte;
    run_tokens.delete();
    if (item.has_byte) begin
      pos = byte_pos;
      if (byte_pos != exl_pkg::POS_MAX) byte_pos++;
      case (scan_mode)
        SCAN_ERROR: ;
        SCAN_HELD: begin
          if (c == "=") begin
            add_token(held_ch == "!" ? exl_pkg::KIND_NE :
                      held_ch == "<" ? exl_pkg::KIND_LE :
                      held_ch == ">" ? exl_pkg::KIND_GE : exl_pkg::KIND_EQ,
                      tok_start, LEN_TWO, '0, 1'b0);
            scan_mode = SCAN_IDLE;
          end else begin
            // A lone bang swallows the byte after it.
            bang = (held_ch == "!");
            flush_token();
            if (!bang) begin_token(c, pos);
          end
        end
        SCAN_IDENT: begin
          if (is_word(c)) begin
            if (tok_len != exl_pkg::POS_MAX) tok_len++;
            if (kw_prog < KW_FULL && c == keyword_char(kw_prog)) kw_prog++;
            else kw_prog = KW_NONE;
          end else begin
            flush_token();
            begin_token(c, pos);
          end
        end
        SCAN_NUM: begin
          if (c >= "0" && c <= "9") begin
            digit = 32'(c - "0");
            if (tok_len != exl_pkg::POS_MAX) tok_len++;
            if (num_ovf ||
                64'(num_acc) > (64'(exl_pkg::VAL_MAX) - 64'(digit)) / 64'd10) begin
              num_ovf = 1'b1;
              num_acc = exl_pkg::VAL_MAX;
            end else begin
              num_acc = VB'(num_acc * 10 + digit);
            end
          end else begin
            flush_token();
            begin_token(c, pos);
          end
        end
        default: begin_token(c, pos);
      endcase
    end
    if (item.end_of_input) begin
      if (scan_mode != SCAN_ERROR) flush_token();
      add_token(exl_pkg::KIND_EOF, byte_pos, LEN_ZERO, '0, 1'b0);
      clear_scanner();
    end
    if (run_tokens.size() > 0) begin
      tail = run_tokens.pop_back();
      tail.last_of_run = 1'b1;
      run_tokens.push_back(tail);
    end
    foreach (run_tokens[i]) token_expect.push_back(run_tokens[i]);
  endtask

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    errors++;
    if (errors <= PRINT_CAP) $display("ERROR: token %0d: %s", tokens_seen, what);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
  endtask

  task automatic check_token(exl_pkg::token_t got, exl_pkg::token_t want);
    check_field("token_kind", 64'(got.token_kind), 64'(want.token_kind));
    check_field("start_pos", 64'(got.start_pos), 64'(want.start_pos));
    check_field("token_len", 64'(got.token_len), 64'(want.token_len));
    check_field("num_value", 64'(got.num_value), 64'(want.num_value));
    check_field("value_saturated", 64'(got.value_saturated), 64'(want.value_saturated));
    check_field("last_of_run", 64'(got.last_of_run), 64'(want.last_of_run));
    if (want.token_kind <= exl_pkg::KIND_ERROR) kinds_seen[want.token_kind] = 1'b1;
    if (want.value_saturated) sat_seen++;
  endtask

  // Transfers are taken and tokens checked at the rising edge.
  always @(posedge clk) begin
    byte_moved = 1'b0;
    if (!rst) begin
      if (byte_valid && !byte_stall) begin
        lex_item(byte_data);
        byte_moved = 1'b1;
        items_taken++;
      end
      if (token_valid && !token_stall) begin
        tokens_seen++;
        if (token_expect.size() == 0)
          report_mismatch($sformatf("unexpected token of kind %0d at %0d",
                                    token_data.token_kind, token_data.start_pos));
        else
          check_token(token_data, token_expect.pop_front());
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst && (!byte_valid || byte_moved)) begin
      if (text_queue.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
        byte_data  <= text_queue.pop_front();
        byte_valid <= 1'b1;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random, and once holds off long enough to fill the block.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      token_stall <= 1'b1;
      hold_left--;
    end else if (!hold_used && items_taken >= HOLD_AT_ITEM) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES - 1;
      token_stall <= 1'b1;
    end else begin
      token_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d tokens outstanding", cycles,
               token_expect.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic push_item(logic [7:0] c, logic has, logic last);
    exl_pkg::byte_t item;
    item.text_byte    = c;
    item.has_byte     = has;
    item.end_of_input = last;
    text_queue.push_back(item);
    if (has || last) stim_items++;
  endtask

  task automatic push_text(string s, bit close);
    for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b1, close && i == s.len() - 1);
  endtask

  function automatic logic [7:0] word_char();
    return WORD_CHARS[$urandom_range(0, WORD_CHARS.len() - 1)];
  endfunction

  task automatic push_digits(int count);
    repeat (count) push_item(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
  endtask

  task automatic push_random_piece();
    int         sel;
    int         n;
    logic [7:0] c;
    sel = $urandom_range(0, 99);
    if (sel < 20) begin
      push_item(8'("a" + $urandom_range(0, 25)), 1'b1, 1'b0);
      repeat ($urandom_range(0, 5)) push_item(word_char(), 1'b1, 1'b0);
    end else if (sel < 28) begin
      // Full keyword or a prefix of it, sometimes running on into a longer word.
      n = $urandom_range(3, 6);
      for (int i = 0; i < n; i++) push_item(keyword_char(3'(i)), 1'b1, 1'b0);
      if ($urandom_range(0, 1)) push_item(word_char(), 1'b1, 1'b0);
    end else if (sel < 46) begin
      case ($urandom_range(0, 5))
        0: push_text("2147483647", 1'b0);
        1: push_text("2147483648", 1'b0);
        2: push_digits($urandom_range(10, 14));
        default: push_digits($urandom_range(1, 4));
      endcase
    end else if (sel < 66) begin
      push_item(OP_CHARS[$urandom_range(0, OP_CHARS.len() - 1)], 1'b1, 1'b0);
    end else if (sel < 76) begin
      push_item(CMP_HEADS[$urandom_range(0, 3)], 1'b1, 1'b0);
      push_item("=", 1'b1, 1'b0);
    end else if (sel < 88) begin
      repeat ($urandom_range(1, 3)) begin
        c = 8'($urandom_range(9, 14));
        push_item(c == 8'd14 ? " " : c, 1'b1, 1'b0);
      end
    end else if (sel < 93) begin
      push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end else if (sel < 96) begin
      push_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else begin
      push_item("!", 1'b1, 1'b0);
      push_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
  endtask

  initial begin
    exl_pkg::byte_t tail;
    int             goal;
    clear_scanner();

    // Every token kind but GE, digits running into letters, held operators flushed by
    // the next byte, a bare item, a bare end marker, unknown bytes and a lone bang.
    push_text("return<=x>9==(y)+-*/;", 1'b1);
    push_text("12ab", 1'b0);
    push_item(8'hA5, 1'b0, 1'b0);
    push_text("<c=!=", 1'b0);
    push_item(8'h5A, 1'b0, 1'b1);
    push_item(8'h00, 1'b1, 1'b1);
    push_item(8'hFF, 1'b1, 1'b1);
    push_text("!xZ", 1'b1);
    texts = 5;

    goal = stim_items + RANDOM_ITEMS;
    while (stim_items < goal) begin
      repeat ($urandom_range(2, 10)) push_random_piece();
      if ($urandom_range(0, 1)) begin
        push_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
      end else begin
        tail = text_queue.pop_back();
        tail.end_of_input = 1'b1;
        text_queue.push_back(tail);
      end
      texts++;
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (text_queue.size() != 0 || byte_valid) @(posedge clk);
    while (token_expect.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Lexed %0d items in %0d texts with random gaps and one long receiver hold.",
             stim_items, texts);
    $display("Checked %0d tokens: %0d of 19 kinds, %0d saturated numbers.", tokens_seen,
             $countones(kinds_seen), sat_seen);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
